### rtl/core/assert_macros.svh
// assertion macros used by the checker file of the project
// depends on nothing; take it in by include with the bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent and consequent in the same cycle
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// consequent in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

### rtl/core/ppq_pkg.sv
// shared types and constants of the polygon point query block
// depends on nothing
`default_nettype none

package ppq_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 64;

  localparam int unsigned COORD_W     = 16;
  localparam int unsigned SLOT_W      = 6;
  localparam int unsigned CNT_W       = 7;
  localparam int unsigned DIST_W      = 33;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 72;

  localparam logic [CNT_W-1:0] COUNT_RESET = 7'd3;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_OUTW
  } ppq_state_t;

  // control travelling alongside each vertex read
  typedef struct packed {
    logic valid;
    logic prime;
    logic last;
  } ppq_ctl_t;

  typedef struct packed {
    logic                      in_poly;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [SLOT_W-1:0]         slot;
    logic [DIST_W-1:0]         dist_sq;
  } ppq_res_t;

endpackage

`default_nettype wire

### rtl/core/ppq_edge_unit.sv
// shared edge and distance unit: one vertex per cycle through three stages
// depends on ppq_pkg
`default_nettype none

module ppq_edge_unit
  import ppq_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic signed [COORD_W-1:0]                 qx,
  input  wire logic signed [COORD_W-1:0]                 qy,
  input  wire ppq_ctl_t                                  ctl,
  input  wire logic [(MAX_VERTICES > 1 ? $clog2(MAX_VERTICES) : 1)-1:0] idx,
  input  wire logic signed [COORD_W-1:0]                 vx,
  input  wire logic signed [COORD_W-1:0]                 vy,
  output logic                                           done,
  output ppq_res_t                                       res
);

  localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned DW = COORD_W + 1;
  localparam int unsigned PW = 2 * DW;

  // previous vertex of the walk, edge end j
  logic signed [COORD_W-1:0] prev_x_r, prev_y_r;

  // stage a: differences
  logic signed [DW-1:0] a_r, b_r, c_r, d_r;
  logic signed [DW-1:0] a_nxt, b_nxt, c_nxt, d_nxt;
  logic                 va_r, lasta_r, strad_a_r, dpos_a_r;
  logic [AW-1:0]        idxa_r;
  logic signed [COORD_W-1:0] xa_r, ya_r;

  // stage b: products
  logic signed [PW-1:0] lhs_r, rhs_r;
  logic signed [PW-1:0] lhs_nxt, rhs_nxt, sqa_full, sqc_full;
  logic [PW-3:0]        sqa_r, sqc_r;
  logic                 vb_r, lastb_r, strad_b_r, dpos_b_r;
  logic [AW-1:0]        idxb_r;
  logic signed [COORD_W-1:0] xb_r, yb_r;

  // stage c: accumulate
  logic                 edge_hit;
  logic                 first;
  logic [DIST_W-1:0]    dd;
  logic                 parity_r;
  logic [DIST_W-1:0]    best_d_r;
  logic [AW-1:0]        best_idx_r;
  logic signed [COORD_W-1:0] best_x_r, best_y_r;
  logic                 done_r;

  always_comb begin
    a_nxt = {qx[COORD_W-1], qx} - {vx[COORD_W-1], vx};
    b_nxt = {prev_x_r[COORD_W-1], prev_x_r} - {vx[COORD_W-1], vx};
    c_nxt = {qy[COORD_W-1], qy} - {vy[COORD_W-1], vy};
    d_nxt = {prev_y_r[COORD_W-1], prev_y_r} - {vy[COORD_W-1], vy};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= ctl.valid && !ctl.prime;
    end
    if (ctl.valid) begin
      prev_x_r <= vx;
      prev_y_r <= vy;
    end
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    c_r       <= c_nxt;
    d_r       <= d_nxt;
    strad_a_r <= (vy > qy) != (prev_y_r > qy);
    dpos_a_r  <= d_nxt > 0;
    lasta_r   <= ctl.last;
    idxa_r    <= idx;
    xa_r      <= vx;
    ya_r      <= vy;
  end

  always_comb begin
    lhs_nxt  = a_r * d_r;
    rhs_nxt  = b_r * c_r;
    sqa_full = a_r * a_r;
    sqc_full = c_r * c_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else begin
      vb_r <= va_r;
    end
    lhs_r     <= lhs_nxt;
    rhs_r     <= rhs_nxt;
    sqa_r     <= sqa_full[PW-3:0];
    sqc_r     <= sqc_full[PW-3:0];
    lastb_r   <= lasta_r;
    strad_b_r <= strad_a_r;
    dpos_b_r  <= dpos_a_r;
    idxb_r    <= idxa_r;
    xb_r      <= xa_r;
    yb_r      <= ya_r;
  end

  // sign of the edge's dy decides which way the cross-multiplied test points
  always_comb begin
    edge_hit = strad_b_r && (dpos_b_r ? (lhs_r < rhs_r) : (lhs_r > rhs_r));
    dd       = {1'b0, sqa_r} + {1'b0, sqc_r};
    first    = (idxb_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= vb_r && lastb_r;
    end
    if (vb_r) begin
      parity_r <= (first ? 1'b0 : parity_r) ^ edge_hit;
      if (first || (dd < best_d_r)) begin
        best_d_r   <= dd;
        best_idx_r <= idxb_r;
        best_x_r   <= xb_r;
        best_y_r   <= yb_r;
      end
    end
  end

  assign done        = done_r;
  assign res.in_poly = parity_r;
  assign res.x       = best_x_r;
  assign res.y       = best_y_r;
  assign res.slot    = SLOT_W'(best_idx_r);
  assign res.dist_sq = best_d_r;

endmodule

`default_nettype wire

### rtl/core/polygon_point_query.sv
// polygon point query: top level with vertex store, sequencer and output register
// depends on ppq_pkg and ppq_edge_unit
//
// usage
//   input stream: in_tuser selects load (0) or query (1); in_tdata carries the
//   point and, for a load, the store slot. a load writes one vertex and gives
//   no result; the block is ready again at once.
//   a query walks the first n stored vertices (n = vertex_count clamped to
//   1..MAX_VERTICES) and gives one result transaction: inside flag by the
//   even-odd rule, nearest vertex, its slot and squared distance.
//   a query holds in_tready low until its result enters the output register:
//   the store, with one read and one write port, is read once per cycle (n + 1
//   reads, the closing vertex first) and each read passes a three-stage edge
//   and distance unit.
//   output: out_tvalid/out_tdata sit in a register; while it waits, loads and a
//   new query are still taken. a finished query whose result finds the register
//   still full waits for out_tready before the block is ready again.
//   configuration: cfg_we writes vertex_count; write only while idle.
//   reset (rst_n low, synchronous): vertex_count returns to 3, the output is
//   emptied; the store is not cleared and slots must be loaded before use.
`default_nettype none

module polygon_point_query
  import ppq_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,  // coord_x, coord_y, vertex_slot, zero pad
  input  wire logic                   in_tuser,  // command
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata, // inside_res, nearest_x, nearest_y,
                                                 // nearest_slot, nearest_dist_sq
  input  wire logic                   cfg_we,
  input  wire logic [CNT_W-1:0]       cfg_wdata
);

  localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned MW = 2 * COORD_W;

  logic signed [COORD_W-1:0] in_x, in_y;
  logic [SLOT_W-1:0]         in_slot;
  logic                      in_acc;

  logic [CNT_W-1:0]          cfg_count_r;
  ppq_state_t                state_r, state_nxt;
  logic signed [COORD_W-1:0] qx_r, qy_r;
  logic [CW-1:0]             n_r, n_clamp;
  logic [CW-1:0]             k_r, k_nxt;

  logic [MW-1:0]             mem [MAX_VERTICES];
  logic                      mem_we;
  logic [AW-1:0]             rd_addr;
  logic [MW-1:0]             rd_data_r;
  ppq_ctl_t                  ctl_nxt, ctl_s1_r;
  logic [AW-1:0]             idx_nxt, idx_s1_r;

  logic                      eu_done;
  ppq_res_t                  eu_res;
  logic                      out_load;
  logic                      out_tvalid_r;
  logic [OUT_TDATA_W-1:0]    out_tdata_r;

  assign in_x    = in_tdata[COORD_W-1:0];
  assign in_y    = in_tdata[2*COORD_W-1:COORD_W];
  assign in_slot = in_tdata[2*COORD_W+SLOT_W-1:2*COORD_W];
  assign in_acc  = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_count_r <= COUNT_RESET;
    end else if (cfg_we) begin
      cfg_count_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (cfg_count_r == '0) begin
      n_clamp = CW'(1);
    end else if (32'(cfg_count_r) > 32'(MAX_VERTICES)) begin
      n_clamp = CW'(MAX_VERTICES);
    end else begin
      n_clamp = CW'(cfg_count_r);
    end
  end

  // vertex store, one port each way
  assign mem_we = in_acc && (in_tuser == CMD_LOAD) && (32'(in_slot) < 32'(MAX_VERTICES));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(in_slot)] <= {in_y, in_x};
    end
    rd_data_r <= mem[rd_addr];
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    in_tready     = 1'b0;
    out_load      = 1'b0;
    ctl_nxt.valid = 1'b0;
    ctl_nxt.prime = (k_r == '0);
    ctl_nxt.last  = (k_r == n_r);
    idx_nxt       = AW'(k_r - CW'(1));
    // first read fetches the closing vertex so edge 0 wraps
    rd_addr       = (k_r == '0) ? AW'(n_r - CW'(1)) : AW'(k_r - CW'(1));
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        k_nxt     = '0;
        if (in_tvalid && (in_tuser == CMD_QUERY)) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        ctl_nxt.valid = 1'b1;
        k_nxt         = k_r + CW'(1);
        if (k_r == n_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (eu_done) begin
          state_nxt = ST_OUTW;
        end
      end
      ST_OUTW: begin
        if (!out_tvalid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      k_r            <= '0;
      ctl_s1_r.valid <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      k_r            <= k_nxt;
      ctl_s1_r.valid <= ctl_nxt.valid;
    end
    ctl_s1_r.prime <= ctl_nxt.prime;
    ctl_s1_r.last  <= ctl_nxt.last;
    idx_s1_r       <= idx_nxt;
    if (in_acc && (in_tuser == CMD_QUERY)) begin
      qx_r <= in_x;
      qy_r <= in_y;
      n_r  <= n_clamp;
    end
  end

  ppq_edge_unit #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_edge_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .qx    (qx_r),
    .qy    (qy_r),
    .ctl   (ctl_s1_r),
    .idx   (idx_s1_r),
    .vx    (rd_data_r[COORD_W-1:0]),
    .vy    (rd_data_r[MW-1:COORD_W]),
    .done  (eu_done),
    .res   (eu_res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
    if (out_load) begin
      out_tdata_r <= {eu_res.dist_sq, eu_res.slot, eu_res.y, eu_res.x, eu_res.in_poly};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

`default_nettype wire

### rtl/core/ppq_checker.sv
// port-level checker for polygon_point_query, bound to the top level
// depends on ppq_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module ppq_checker
  import ppq_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic                   in_tuser,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata
);

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  // a query occupies the block
  `ASSERT_NEXT(a_query_busy, clk, rst_n, in_acc && (in_tuser == CMD_QUERY), !in_tready)

  // a load never occupies the block
  `ASSERT_NEXT(a_load_free, clk, rst_n, in_acc && (in_tuser == CMD_LOAD), in_tready)

  // a result is handed over at the end of its query
  `ASSERT_SAME(a_result_ends_query, clk, rst_n, $rose(out_tvalid), in_tready)

  // a waiting result holds
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
               out_tvalid && $stable(out_tdata))

endmodule

bind polygon_point_query ppq_checker u_ppq_checker (.*);

`default_nettype wire
